FILE: hw/rtl/lbsu_pkg.sv
// Shared types and constants for the logger block sample unpacker.
// Register indexes, reset values and the structs passed between modules.
// No dependencies.
package lbsu_pkg;

  // Default framing geometry
  localparam int unsigned ChannelsDef    = 2;
  localparam int unsigned SampleBytesDef = 3;

  // Field widths
  localparam int unsigned ValueW  = 24;
  localparam int unsigned IndexW  = 32;
  localparam int unsigned SpbW    = 16;
  localparam int unsigned HdrW    = 10;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values
  localparam logic [SpbW-1:0]   SpbRst   = 16'd32;
  localparam logic [HdrW-1:0]   HdrRst   = 10'd0;
  localparam logic [IndexW-1:0] SkipRst  = 32'd0;
  localparam logic [IndexW-1:0] CountRst = 32'd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLES_PER_BLOCK = 2'd0,
    REG_HEADER_LENGTH     = 2'd1,
    REG_SKIP_SAMPLES      = 2'd2,
    REG_SAMPLE_COUNT      = 2'd3
  } cfg_reg_e;

  // Completed frame, from deframer to window logic
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] first;
    logic [ValueW-1:0] second;
  } frame_ev_t;

  // Window decision for the current frame
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [IndexW-1:0] idx;
  } win_res_t;

endpackage

FILE: hw/rtl/logger_block_sample_unpacker.sv
// Top level of the logger block sample unpacker: config registers, input
// word register, result register and the deframer and window submodules.
// Depends on lbsu_pkg, lbsu_deframer and lbsu_window.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  s_axis  | in        | tvalid / tready      | tdata[7:0] data_byte
//  m_axis  | out       | tvalid / tready      | tdata first, second, index; tlast
//  cfg     | in        | we (no back-pressure)| idx, data
//
// One byte is accepted per cycle sustained while the output is not stalled.
// An accepted byte is held in the input register; when it advances, the deframer
// and window logic update and a finished pair lands in the result register.
// The result register frees while downstream takes the word, so a stalled
// output only blocks input once both registers are full.
// Reset is asynchronous, active low; no clearing pass is needed.
module logger_block_sample_unpacker #(
  parameter int unsigned CHANNELS     = lbsu_pkg::ChannelsDef,
  parameter int unsigned SAMPLE_BYTES = lbsu_pkg::SampleBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [lbsu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lbsu_pkg::CfgW-1:0]    cfg_data_i,
  // Byte stream in
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,   // [7:0] data_byte
  // Sample pairs out
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [23:0] first_channel, [47:24] second_channel, [79:48] sample_index
  output logic [79:0]                  m_axis_tdata_o,
  output logic                         m_axis_tlast_o    // last
);
  import lbsu_pkg::*;

  logic [SpbW-1:0]   spb_q;
  logic [HdrW-1:0]   hdr_len_q;
  logic [IndexW-1:0] skip_q, count_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       adv, s_acc, done;

  logic              out_valid_q, out_last_q;
  logic [ValueW-1:0] out_first_q, out_second_q;
  logic [IndexW-1:0] out_idx_q;

  frame_ev_t frame;
  win_res_t  res;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q     <= SpbRst;
      hdr_len_q <= HdrRst;
      skip_q    <= SkipRst;
      count_q   <= CountRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SAMPLES_PER_BLOCK: spb_q     <= cfg_data_i[SpbW-1:0];
        REG_HEADER_LENGTH:     hdr_len_q <= cfg_data_i[HdrW-1:0];
        REG_SKIP_SAMPLES:      skip_q    <= cfg_data_i[IndexW-1:0];
        REG_SAMPLE_COUNT:      count_q   <= cfg_data_i[IndexW-1:0];
        default: ;
      endcase
    end
  end

  // Advance when the result register can take whatever this word yields
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Hold the accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_acc) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  lbsu_deframer #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BYTES(SAMPLE_BYTES)
  ) u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv && !done),
    .byte_i   (in_byte_q),
    .spb_i    (spb_q),
    .hdr_len_i(hdr_len_q),
    .frame_o  (frame)
  );

  lbsu_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .frame_i(frame.valid),
    .skip_i (skip_q),
    .count_i(count_q),
    .res_o  (res),
    .done_o (done)
  );

  // Load or drain the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.emit) begin
      out_first_q  <= frame.first;
      out_second_q <= frame.second;
      out_idx_q    <= res.idx;
      out_last_q   <= res.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_idx_q, out_second_q, out_first_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

FILE: hw/rtl/lbsu_deframer.sv
// Byte-level deframer: header skip, byte/channel/frame position tracking
// and little-endian assembly of the first two channel values.
// Depends on lbsu_pkg.
module lbsu_deframer #(
  parameter int unsigned CHANNELS     = lbsu_pkg::ChannelsDef,
  parameter int unsigned SAMPLE_BYTES = lbsu_pkg::SampleBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                byte_i,
  input  logic [lbsu_pkg::SpbW-1:0] spb_i,
  input  logic [lbsu_pkg::HdrW-1:0] hdr_len_i,
  output lbsu_pkg::frame_ev_t       frame_o
);
  import lbsu_pkg::*;

  localparam int unsigned BW = $clog2(SAMPLE_BYTES);
  localparam int unsigned CW = $clog2(CHANNELS);

  logic            in_hdr_q, in_hdr_d;
  logic [HdrW-1:0] hdr_seen_q, hdr_seen_d;
  logic [BW-1:0]   byte_q, byte_d;
  logic [CW-1:0]   chan_q, chan_d;
  logic [SpbW-1:0] frame_q, frame_d;
  logic [ValueW-1:0] first_q, first_d, second_q, second_d;

  logic [HdrW-1:0]   hdr_inc;
  logic [SpbW:0]     next_frame, limit;
  logic [ValueW-1:0] lane;
  logic              is_data, lane_hit, frame_done;

  // Place the byte into its lane; bytes past the third are dropped
  always_comb begin
    lane     = '0;
    lane_hit = 1'b1;
    if (byte_q == BW'(0)) begin
      lane = {16'd0, byte_i};
    end else if (byte_q == BW'(1)) begin
      lane = {8'd0, byte_i, 8'd0};
    end else if (byte_q == BW'(2)) begin
      lane = {byte_i, 16'd0};
    end else begin
      lane_hit = 1'b0;
    end
  end

  // Advance header, byte, channel and frame positions and assemble the channel values
  always_comb begin
    in_hdr_d   = in_hdr_q;
    hdr_seen_d = hdr_seen_q;
    byte_d     = byte_q;
    chan_d     = chan_q;
    frame_d    = frame_q;
    first_d    = first_q;
    second_d   = second_q;
    is_data    = 1'b0;
    frame_done = 1'b0;
    hdr_inc    = hdr_seen_q + HdrW'(1);
    next_frame = {1'b0, frame_q} + (SpbW+1)'(1);
    limit      = {(spb_i == '0), spb_i};

    if (step_i) begin
      is_data = 1'b1;
      if (in_hdr_q) begin
        if (hdr_seen_q < hdr_len_i) begin
          hdr_seen_d = hdr_inc;
          if (hdr_inc >= hdr_len_i) begin
            in_hdr_d = 1'b0;
          end
          is_data = 1'b0;
        end else begin
          in_hdr_d = 1'b0;
        end
      end

      if (is_data) begin
        if (lane_hit) begin
          if (chan_q == CW'(0)) begin
            first_d = (byte_q == BW'(0)) ? lane : (first_q | lane);
          end else if (chan_q == CW'(1)) begin
            second_d = (byte_q == BW'(0)) ? lane : (second_q | lane);
          end
        end
        if (byte_q != BW'(SAMPLE_BYTES - 1)) begin
          byte_d = byte_q + BW'(1);
        end else begin
          byte_d = '0;
          if (chan_q != CW'(CHANNELS - 1)) begin
            chan_d = chan_q + CW'(1);
          end else begin
            chan_d     = '0;
            frame_done = 1'b1;
            if (next_frame >= limit) begin
              frame_d    = '0;
              in_hdr_d   = 1'b1;
              hdr_seen_d = '0;
            end else begin
              frame_d = next_frame[SpbW-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_hdr_q   <= 1'b1;
      hdr_seen_q <= '0;
      byte_q     <= '0;
      chan_q     <= '0;
      frame_q    <= '0;
      first_q    <= '0;
      second_q   <= '0;
    end else begin
      in_hdr_q   <= in_hdr_d;
      hdr_seen_q <= hdr_seen_d;
      byte_q     <= byte_d;
      chan_q     <= chan_d;
      frame_q    <= frame_d;
      first_q    <= first_d;
      second_q   <= second_d;
    end
  end

  assign frame_o.valid  = frame_done;
  assign frame_o.first  = first_d;
  assign frame_o.second = second_d;

endmodule

FILE: hw/rtl/lbsu_window.sv
// Sample window: running sample counter, skip and count checks, last flag
// and the latch that stops all output after the final sample.
// Depends on lbsu_pkg.
module lbsu_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        frame_i,
  input  logic [lbsu_pkg::IndexW-1:0] skip_i,
  input  logic [lbsu_pkg::IndexW-1:0] count_i,
  output lbsu_pkg::win_res_t          res_o,
  output logic                        done_o
);
  import lbsu_pkg::*;

  logic [IndexW-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [IndexW-1:0] idx;
  logic              sat, emit, last;

  // Decide whether this frame falls inside the window; advance the counter and done latch
  always_comb begin
    idx    = cnt_q - skip_i;
    sat    = (cnt_q == '1);
    emit   = frame_i && (cnt_q >= skip_i) && (idx < count_i);
    last   = (idx == (count_i - IndexW'(1))) || sat;
    cnt_d  = (frame_i && !sat) ? cnt_q + IndexW'(1) : cnt_q;
    done_d = done_q || (emit && last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign res_o.emit = emit;
  assign res_o.last = last;
  assign res_o.idx  = idx;
  assign done_o     = done_q;

endmodule

FILE: hw/rtl/lbsu_checker.sv
// Port-level checker for the logger block sample unpacker, bound to the
// top level. Depends only on the top level's ports.
module lbsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic win_done_q;

  // Note the final word of the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_done_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) begin
      win_done_q <= 1'b1;
    end
  end

  a_no_word_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_done_q |-> !m_axis_tvalid_o)
    else $error("word offered after the last word of the window");

  a_idle_out_of_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid on the first edge after reset");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("output word changed while stalled");

endmodule

bind logger_block_sample_unpacker lbsu_checker u_lbsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

FILE: bench/testbench.sv
// Self-checking bench for the logger block sample unpacker: drives a byte stream,
// predicts every sample pair and compares each output word field by field.
// Depends on lbsu_pkg and logger_block_sample_unpacker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lbsu_pkg::*;

  localparam int unsigned StallMax      = 19;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ItemTarget    = 1600;
  localparam int unsigned SettleCycles  = 4;
  // counts at or above this cannot close the window within one run
  localparam logic [IndexW-1:0] SafeCount = 32'h0001_0000;

  typedef struct packed {
    logic [ValueW-1:0] first_ch;
    logic [ValueW-1:0] second_ch;
    logic [IndexW-1:0] index;
    logic              is_last;
  } pair_t;

  typedef enum logic { ROW_WRITE, ROW_BYTE } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    cfg_reg_e        reg_sel;
    logic [CfgW-1:0] value;
    logic            pinned;
    pair_t           pin;
  } row_t;

  localparam pair_t NoPin = '0;
  localparam int unsigned PlanRows = 31;

  // Directed opening: register writes and stream bytes, typed pairs where obvious
  localparam row_t Plan [PlanRows] = '{
    '{ROW_WRITE, REG_SAMPLE_COUNT,      32'hFFFF_FFFF, 1'b0, NoPin},
    // most negative first channel, most positive second channel
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h00, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h00, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h80, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'hFF, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'hFF, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h7F, 1'b1,
      '{24'h800000, 24'h7FFFFF, 32'd0, 1'b0}},
    // minus one and zero
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'hFF, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'hFF, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'hFF, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h00, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h00, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h00, 1'b1,
      '{24'hFFFFFF, 24'h000000, 32'd1, 1'b0}},
    // shrink the block mid-block and add a header
    '{ROW_WRITE, REG_SAMPLES_PER_BLOCK, 32'd1, 1'b0, NoPin},
    '{ROW_WRITE, REG_HEADER_LENGTH,     32'd2, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h12, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h34, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h56, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h78, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h9A, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'hBC, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h55, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'hAA, 1'b0, NoPin},
    // skip everything, zero count: no pair
    '{ROW_WRITE, REG_SKIP_SAMPLES,      32'hFFFF_FFFF, 1'b0, NoPin},
    '{ROW_WRITE, REG_SAMPLE_COUNT,      32'd0, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h01, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h02, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h03, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h04, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h05, 1'b0, NoPin},
    '{ROW_BYTE,  REG_SAMPLES_PER_BLOCK, 32'h06, 1'b0, NoPin}
  };

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = '0;
  logic [CfgW-1:0]      cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic [7:0]           s_tdata   = '0;
  logic                 m_tready  = 1'b1;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [79:0]          m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  bit                   gaps_on   = 1'b0;
  bit                   stalls_on = 1'b0;
  int unsigned          mismatches;
  int unsigned          bytes_sent;
  int unsigned          quiet_cycles;
  pair_t                expected_pairs [$];

  // Predicted register copies
  logic [SpbW-1:0]      cfg_spb   = SpbRst;
  logic [HdrW-1:0]      cfg_hdr   = HdrRst;
  logic [IndexW-1:0]    cfg_skip  = SkipRst;
  logic [IndexW-1:0]    cfg_count = CountRst;

  // Predicted deframer and window state
  bit                   hdr_active    = 1'b1;
  logic [HdrW-1:0]      hdr_seen      = '0;
  int unsigned          byte_pos      = 0;
  int unsigned          chan_pos      = 0;
  int unsigned          frame_pos     = 0;
  logic [IndexW-1:0]    frame_total   = '0;
  logic [ValueW-1:0]    acc_first     = '0;
  logic [ValueW-1:0]    acc_second    = '0;
  bit                   window_closed = 1'b0;

  logger_block_sample_unpacker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the deframer by one stream byte; yields a pair when the window emits
  function automatic void deframe_byte(input logic [7:0] b, output bit produced,
                                       output pair_t pair);
    logic [IndexW-1:0] rel;
    logic [16:0]       blk_len;
    bit                hit;
    produced = 1'b0;
    pair     = '0;
    if (window_closed) return;
    if (hdr_active) begin
      if (hdr_seen < cfg_hdr) begin
        hdr_seen = hdr_seen + 1'b1;
        if (hdr_seen >= cfg_hdr) hdr_active = 1'b0;
        return;
      end
      hdr_active = 1'b0;
    end
    // Only the lowest three bytes of the first two channels are kept
    if (chan_pos == 0) begin
      if (byte_pos == 0) acc_first = ValueW'(b);
      else if (byte_pos < 3) acc_first[8*byte_pos +: 8] = b;
    end else if (chan_pos == 1) begin
      if (byte_pos == 0) acc_second = ValueW'(b);
      else if (byte_pos < 3) acc_second[8*byte_pos +: 8] = b;
    end
    if (byte_pos + 1 < SampleBytesDef) begin
      byte_pos++;
      return;
    end
    byte_pos = 0;
    if (chan_pos + 1 < ChannelsDef) begin
      chan_pos++;
      return;
    end
    chan_pos = 0;
    // Frame complete: window decision, then block bookkeeping
    rel  = frame_total - cfg_skip;
    hit  = (frame_total >= cfg_skip) && (rel < cfg_count);
    pair = '{acc_first, acc_second, rel,
             (rel == cfg_count - 1'b1) || (frame_total == '1)};
    if (frame_total != '1) frame_total = frame_total + 1'b1;
    blk_len = (cfg_spb == '0) ? 17'd65536 : {1'b0, cfg_spb};
    if (frame_pos + 1 >= blk_len) begin
      frame_pos  = 0;
      hdr_active = 1'b1;
      hdr_seen   = '0;
    end else begin
      frame_pos++;
    end
    produced = hit;
    if (hit && pair.is_last) window_closed = 1'b1;
  endfunction

  task automatic report(input string what, input logic [IndexW-1:0] got,
                        input logic [IndexW-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Hold off the stream until every pair has come and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CfgW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= value;
    @(posedge clk_i);
    case (sel)
      REG_SAMPLES_PER_BLOCK: cfg_spb   = value[SpbW-1:0];
      REG_HEADER_LENGTH:     cfg_hdr   = value[HdrW-1:0];
      REG_SKIP_SAMPLES:      cfg_skip  = value[IndexW-1:0];
      REG_SAMPLE_COUNT:      cfg_count = value[IndexW-1:0];
      default: ;
    endcase
  endtask

  // Offer one stream word, wait for the handshake and predict its effect
  task automatic send_byte(input logic [7:0] value, input bit pinned, input pair_t pin);
    bit    produced;
    pair_t pair;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, StallMax)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    deframe_byte(value, produced, pair);
    if (produced) expected_pairs.insert(expected_pairs.size(), pinned ? pin : pair);
    bytes_sent++;
  endtask

  // One random phase: new settings while idle, then a run of bytes
  task automatic run_phase(input int unsigned len);
    logic [CfgW-1:0] value;
    logic [CfgW-1:0] skip_val;
    logic [CfgW-1:0] count_val;
    bit              count_due;
    logic [7:0]      data;
    settle();
    gaps_on   = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 7))
        0:       value = 1;
        1:       value = 2;
        2, 3, 4: value = $urandom_range(1, 8);
        5:       value = 0;
        6:       value = 32'h0000_FFFF;
        default: value = $urandom_range(0, 16'hFFFF);
      endcase
      write_reg(REG_SAMPLES_PER_BLOCK, value);
    end
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 8))
        0, 1, 2:    value = 0;
        3, 4, 5, 6: value = $urandom_range(1, 8);
        7:          value = $urandom_range(0, 1023);
        default:    value = 1023;
      endcase
      write_reg(REG_HEADER_LENGTH, value);
    end
    skip_val = cfg_skip;
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 9))
        0, 1, 2: skip_val = 0;
        3, 4, 5: skip_val = $urandom_range(0, frame_total);
        6, 7:    skip_val = frame_total + $urandom_range(0, 30);
        8:       skip_val = $urandom;
        default: skip_val = 32'hFFFF_FFFF;
      endcase
      write_reg(REG_SKIP_SAMPLES, skip_val);
    end
    count_val = cfg_count;
    count_due = ($urandom_range(0, 1) == 1);
    if (count_due) begin
      case ($urandom_range(0, 9))
        0:          count_val = 0;
        1:          count_val = (skip_val < frame_total) ?
                                $urandom_range(1, frame_total - skip_val) : 32'hFFFF_FFFF;
        2, 3, 4, 5: count_val = 32'hFFFF_FFFF;
        default:    count_val = $urandom_range(SafeCount, 32'hFFFF_FFFF);
      endcase
    end
    // Keep the window open until the closing phase
    if (!(count_val == 0 || count_val >= SafeCount ||
          (skip_val <= frame_total && frame_total - skip_val >= count_val))) begin
      count_val = 32'hFFFF_FFFF;
      count_due = 1'b1;
    end
    if (count_due) write_reg(REG_SAMPLE_COUNT, count_val);
    cfg_we <= 1'b0;
    repeat (len) begin
      data = $urandom_range(0, 255);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          2:       data = 8'h80;
          default: data = 8'h7F;
        endcase
      end
      send_byte(data, 1'b0, NoPin);
    end
  endtask

  // Receiver back-pressure in bursts
  always begin
    @(posedge clk_i);
    if (stalls_on && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, StallMax)) @(posedge clk_i);
      m_tready <= 1'b1;
    end
  end

  // Compare each output word with the oldest predicted pair
  always @(posedge clk_i) begin
    pair_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_pairs.size() == 0) begin
        report("pair with none pending, index", m_axis_tdata_o[79:48], '0);
      end else begin
        want = expected_pairs.pop_front();
        if (m_axis_tdata_o[23:0] !== want.first_ch)
          report("first_channel", IndexW'(m_axis_tdata_o[23:0]), IndexW'(want.first_ch));
        if (m_axis_tdata_o[47:24] !== want.second_ch)
          report("second_channel", IndexW'(m_axis_tdata_o[47:24]), IndexW'(want.second_ch));
        if (m_axis_tdata_o[79:48] !== want.index)
          report("sample_index", m_axis_tdata_o[79:48], want.index);
        if (m_axis_tlast_o !== want.is_last)
          report("last", IndexW'(m_axis_tlast_o), IndexW'(want.is_last));
      end
    end
  end

  // Drop the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    bit          writing;
    int unsigned tail;
    writing = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening
    for (int i = 0; i < PlanRows; i++) begin
      if (Plan[i].kind == ROW_WRITE) begin
        if (!writing) settle();
        write_reg(Plan[i].reg_sel, Plan[i].value);
        writing = 1'b1;
      end else begin
        if (writing) cfg_we <= 1'b0;
        writing = 1'b0;
        send_byte(Plan[i].value[7:0], Plan[i].pinned, Plan[i].pin);
      end
    end

    // Random phases
    while (bytes_sent < ItemTarget)
      run_phase($urandom_range(20, 120));

    // Close the window with a short count and no idling, then feed ignored bytes
    settle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (!m_tready) @(posedge clk_i);
    tail      = $urandom_range(1, 8);
    write_reg(REG_SAMPLES_PER_BLOCK, '0);
    write_reg(REG_HEADER_LENGTH, '0);
    write_reg(REG_SKIP_SAMPLES, frame_total);
    write_reg(REG_SAMPLE_COUNT, tail);
    cfg_we <= 1'b0;
    repeat (6 * (tail + 1) + 24) send_byte($urandom_range(0, 255), 1'b0, NoPin);
    s_tvalid <= 1'b0;

    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lbsu_pkg.sv
hw/rtl/lbsu_deframer.sv
hw/rtl/lbsu_window.sv
hw/rtl/logger_block_sample_unpacker.sv
hw/rtl/lbsu_checker.sv
bench/testbench.sv
